[sv/dts_pkg.sv]
// Shared field widths and operation codes for the deadline timer scheduler.
package dts_pkg;

  localparam int OP_W      = 3;
  localparam int SLOT_W    = 6;
  localparam int TIME_W    = 63;
  // Wide enough to hold a slot index for the largest slot count supported.
  localparam int IDX_EXT_W = 10;

  localparam logic [OP_W-1:0] OP_SET     = 3'd0;
  localparam logic [OP_W-1:0] OP_ENSURE  = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd2;
  localparam logic [OP_W-1:0] OP_PROCESS = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;

  localparam int ZERO_REPAIR_DELAY = 2000;

endpackage

[sv/dts_cmd_if.sv]
// Command channel of the deadline timer scheduler.
interface dts_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [dts_pkg::OP_W-1:0]        op;
  logic [dts_pkg::SLOT_W-1:0]      slot;
  logic [dts_pkg::TIME_W-1:0]      target_time;
  logic [dts_pkg::TIME_W-1:0]      now;

  modport source (output valid, op, slot, target_time, now, input ready);
  modport sink   (input valid, op, slot, target_time, now, output ready);
endinterface

[sv/dts_res_if.sv]
// Result channel of the deadline timer scheduler.
interface dts_res_if;
  logic                            valid;
  logic                            ready;
  logic                            fired;
  logic [dts_pkg::SLOT_W-1:0]      fired_slot;
  logic                            wake;
  logic [dts_pkg::TIME_W-1:0]      earliest_deadline;
  logic                            queue_empty;
  logic                            last;

  modport source (output valid, fired, fired_slot, wake, earliest_deadline, queue_empty, last,
                  input ready);
  modport sink   (input valid, fired, fired_slot, wake, earliest_deadline, queue_empty, last,
                  output ready);
endinterface

[sv/deadline_timer_scheduler.sv]
// Deadline timer scheduler: per-slot deadlines in a RAM, served earliest first.
//
// Commands arrive on cmd (valid/ready); results leave on res (valid/ready).
// Ops: set, ensure-earlier, clear, process-due, query (codes five to seven act
// as query). Every deadline lives in one single-port-write RAM, and one
// sequencer sweeps it a slot per cycle with a shared min/compare unit; a slot
// holding the all-ones time is unscheduled.
// Set, ensure, clear and query sweep for the earliest deadline before the
// write and sweep again after it, then give the result. Process first
// sweeps once (count of due slots, earliest surviving deadline), then once
// more per due slot removed; each removal is one result, the last one
// flagged. With nothing due a single empty result is given.
// cmd.ready is high only while idle: one command is in flight at a time.
// A stalled receiver holds the result register and the sequencer waits.
// After reset a clearing pass writes every slot unscheduled, during which
// no command is accepted.
module deadline_timer_scheduler #(
  parameter int SLOT_COUNT = 64,
  parameter int TIME_BITS  = 63
) (
  input  logic             clk,
  input  logic             rst,
  dts_cmd_if.sink          cmd,
  dts_res_if.source        res
);

  localparam int TIME_W = dts_pkg::TIME_W;
  localparam int SLOT_W = dts_pkg::SLOT_W;
  localparam int EXT_W  = dts_pkg::IDX_EXT_W;
  localparam int TW     = (TIME_BITS > TIME_W) ? TIME_W : TIME_BITS;
  localparam int SW     = $clog2(SLOT_COUNT);
  localparam int CNT_W  = SW + 1;

  localparam logic [TW-1:0]    NEVER   = {TW{1'b1}};
  localparam logic [TW:0]      REPAIR  = (TW+1)'(dts_pkg::ZERO_REPAIR_DELAY);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SLOT_COUNT);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FIX   = 3'd2;
  localparam logic [2:0] ST_SLOT  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_APPLY = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  // sweep purpose
  localparam logic [1:0] PH_PRE  = 2'd0;  // earliest before a write
  localparam logic [1:0] PH_POST = 2'd1;  // earliest after a write
  localparam logic [1:0] PH_DUE  = 2'd2;  // count due, earliest survivor
  localparam logic [1:0] PH_REM  = 2'd3;  // find next due slot to remove

  logic [2:0]                  state;
  logic [1:0]                  phase;
  logic [dts_pkg::OP_W-1:0]    op_r;
  logic [SLOT_W-1:0]           slot_r;
  logic [TW-1:0]               tgt_r;
  logic [TW-1:0]               now_r;
  logic [TW-1:0]               tgt_eff;
  logic                        do_write;
  logic                        wake_r;
  logic [CNT_W-1:0]            scan_cnt;
  logic                        rd_valid;
  logic [SW-1:0]               rd_idx;
  logic [TW-1:0]               rd_data;
  logic [TW-1:0]               best;
  logic [SW-1:0]               best_idx;
  logic [CNT_W-1:0]            due_cnt;
  logic [TW-1:0]               post_e;

  logic [TW-1:0]               mem [SLOT_COUNT];
  logic                        mem_we;
  logic [SW-1:0]               mem_waddr;
  logic [TW-1:0]               mem_wdata;
  logic [SW-1:0]               rd_addr;

  logic [EXT_W-1:0]            slot_ext;
  logic [SW-1:0]               slot_idx;
  logic [EXT_W-1:0]            best_ext;
  logic                        in_range;
  logic [TW:0]                 repair_sum;
  logic                        filter;
  logic                        lt_best;
  logic                        lt_now;
  logic                        take;
  logic                        scan_done;
  logic                        scan_issue;

  assign slot_ext   = EXT_W'(slot_r);
  assign slot_idx   = slot_ext[SW-1:0];
  assign best_ext   = EXT_W'(best_idx);
  assign in_range   = 32'(slot_r) < SLOT_COUNT;
  assign repair_sum = {1'b0, now_r} + REPAIR;

  assign filter     = phase == PH_DUE;
  assign lt_best    = rd_data < best;
  assign lt_now     = rd_data < now_r;
  assign take       = rd_valid && lt_best && !(filter && lt_now);
  assign scan_issue = scan_cnt != CNT_END;
  assign scan_done  = !scan_issue && !rd_valid;

  assign cmd.ready  = state == ST_IDLE;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_idx;
    mem_wdata = NEVER;
    rd_addr   = slot_idx;
    unique case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = scan_cnt[SW-1:0];
      end
      ST_SCAN: begin
        rd_addr = scan_cnt[SW-1:0];
        if (scan_done && phase == PH_REM) begin
          mem_we    = 1'b1;
          mem_waddr = best_idx;
        end
      end
      ST_APPLY: begin
        mem_we    = do_write;
        mem_wdata = (op_r == dts_pkg::OP_CLEAR) ? NEVER : tgt_eff;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      phase     <= PH_PRE;
      scan_cnt  <= '0;
      rd_valid  <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      unique case (state)
        ST_INIT: begin
          scan_cnt <= scan_cnt + CNT_ONE;
          if (scan_cnt == CNT_END - CNT_ONE) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd.valid) begin
            op_r     <= cmd.op;
            slot_r   <= cmd.slot;
            tgt_r    <= cmd.target_time[TW-1:0];
            now_r    <= cmd.now[TW-1:0];
            wake_r   <= 1'b0;
            scan_cnt <= '0;
            best     <= NEVER;
            best_idx <= '0;
            due_cnt  <= '0;
            if (cmd.op == dts_pkg::OP_PROCESS) begin
              phase <= PH_DUE;
              state <= ST_SCAN;
            end else begin
              state <= ST_FIX;
            end
          end
        end
        ST_FIX: begin
          // zero target repair, saturating one below never
          if (tgt_r == '0) begin
            tgt_eff <= (repair_sum >= {1'b0, NEVER}) ? NEVER - TW'(1) : repair_sum[TW-1:0];
          end else begin
            tgt_eff <= tgt_r;
          end
          state <= ST_SLOT;
        end
        ST_SLOT: begin
          // rd_data holds the slot's current deadline
          do_write <= in_range && (op_r == dts_pkg::OP_SET || op_r == dts_pkg::OP_CLEAR ||
                                   (op_r == dts_pkg::OP_ENSURE && tgt_r < rd_data));
          phase    <= PH_PRE;
          state    <= ST_SCAN;
        end
        ST_SCAN: begin
          rd_valid <= scan_issue;
          rd_idx   <= scan_cnt[SW-1:0];
          if (scan_issue) begin
            scan_cnt <= scan_cnt + CNT_ONE;
          end
          if (take) begin
            best     <= rd_data;
            best_idx <= rd_idx;
          end
          if (rd_valid && filter && lt_now) begin
            due_cnt <= due_cnt + CNT_ONE;
          end
          if (scan_done) begin
            unique case (phase)
              PH_PRE: begin
                state <= ST_APPLY;
              end
              PH_POST: begin
                res.valid             <= 1'b1;
                res.fired             <= 1'b0;
                res.fired_slot        <= '0;
                res.wake              <= wake_r;
                res.earliest_deadline <= TIME_W'(best);
                res.queue_empty       <= best == NEVER;
                res.last              <= 1'b1;
                state                 <= ST_OUT;
              end
              PH_DUE: begin
                post_e <= best;
                if (due_cnt == '0) begin
                  res.valid             <= 1'b1;
                  res.fired             <= 1'b0;
                  res.fired_slot        <= '0;
                  res.wake              <= 1'b0;
                  res.earliest_deadline <= TIME_W'(best);
                  res.queue_empty       <= best == NEVER;
                  res.last              <= 1'b1;
                  state                 <= ST_OUT;
                end else begin
                  phase    <= PH_REM;
                  scan_cnt <= '0;
                  best     <= NEVER;
                  best_idx <= '0;
                end
              end
              PH_REM: begin
                // best_idx is cleared in the RAM this cycle
                res.valid             <= 1'b1;
                res.fired             <= 1'b1;
                res.fired_slot        <= best_ext[SLOT_W-1:0];
                res.wake              <= 1'b0;
                res.earliest_deadline <= TIME_W'(post_e);
                res.queue_empty       <= post_e == NEVER;
                res.last              <= due_cnt == CNT_ONE;
                due_cnt               <= due_cnt - CNT_ONE;
                state                 <= ST_OUT;
              end
              default: ;
            endcase
          end
        end
        ST_APPLY: begin
          // best holds the earliest deadline before the write
          wake_r   <= do_write && op_r != dts_pkg::OP_CLEAR && tgt_eff < best;
          phase    <= PH_POST;
          scan_cnt <= '0;
          best     <= NEVER;
          best_idx <= '0;
          state    <= ST_SCAN;
        end
        ST_OUT: begin
          if (res.ready) begin
            res.valid <= 1'b0;
            if (phase == PH_REM && due_cnt != '0) begin
              scan_cnt <= '0;
              best     <= NEVER;
              best_idx <= '0;
              state    <= ST_SCAN;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
